// ----- sv/ring_gray_histogram_marker_defines.svh -----
// Assertion macros shared by the RTL.
// Clocked on clk, disabled while rst_n is low.
`ifndef RING_GRAY_HISTOGRAM_MARKER_DEFINES_SVH
`define RING_GRAY_HISTOGRAM_MARKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RGHM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RGHM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RGHM_ASSERT_IMP(label, ante, cons, msg)
`define RGHM_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/rghm_pkg.sv -----
package rghm_pkg;

  localparam int COORD_W    = 10;
  localparam int RAD_W      = 11;
  localparam int PIX_W      = 8;
  localparam int COUNT_BITS = 21;
  localparam int NUM_BINS   = 256;
  localparam int BIN_AW     = $clog2(NUM_BINS);
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  // squared-distance widths
  localparam int D2_W  = 2 * COORD_W + 1;
  localparam int RO_W  = RAD_W + 1;
  localparam int SQ_W  = 2 * RAD_W + 1;

  localparam logic [COORD_W-1:0] CENTER_X_RST = COORD_W'(512);
  localparam logic [COORD_W-1:0] CENTER_Y_RST = COORD_W'(512);
  localparam logic [RAD_W-1:0]   OUTER_RST    = RAD_W'(400);
  localparam logic [RAD_W-1:0]   INNER_RST    = RAD_W'(300);

  localparam int THRESH_CENTER = 160;
  localparam int THRESH_SPAN   = 10;
  localparam int EDGE_GUARD    = 5;
  localparam logic [PIX_W-1:0] MARK_THRESH = PIX_W'(THRESH_CENTER - THRESH_SPAN);
  localparam logic [PIX_W-1:0] MARK_VALUE  = PIX_W'(100);

  typedef enum logic [1:0] {
    FUNC_PIXEL = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_OUTER    = 2'd2,
    REG_INNER    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]   outer_radius;
    logic [RAD_W-1:0]   inner_radius;
  } cfg_t;

  typedef struct packed {
    logic in_ring;
    logic guard;
  } ring_t;

endpackage

// ----- sv/rghm_in_if.sv -----
interface rghm_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [rghm_pkg::COORD_W-1:0] col;
  logic [rghm_pkg::COORD_W-1:0] row;
  logic [rghm_pkg::PIX_W-1:0]   pixel_in;

  modport source (output valid, func, col, row, pixel_in, input ready);
  modport sink   (input valid, func, col, row, pixel_in, output ready);
endinterface

// ----- sv/rghm_out_if.sv -----
interface rghm_out_if;
  logic                            valid;
  logic                            ready;
  logic [rghm_pkg::PIX_W-1:0]      pixel_out;
  logic [rghm_pkg::COUNT_BITS-1:0] bin_count;
  logic [rghm_pkg::COUNT_BITS-1:0] max_count;

  modport source (output valid, pixel_out, bin_count, max_count, input ready);
  modport sink   (input valid, pixel_out, bin_count, max_count, output ready);
endinterface

// ----- sv/rghm_ram.sv -----
module rghm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- sv/rghm_ring.sv -----
module rghm_ring (
  input  logic                         clk,
  input  logic                         load,
  input  logic [rghm_pkg::COORD_W-1:0] col,
  input  logic [rghm_pkg::COORD_W-1:0] row,
  input  rghm_pkg::cfg_t               cfg,
  output rghm_pkg::ring_t              ring
);
  import rghm_pkg::*;

  logic [COORD_W-1:0]   dx, dy;
  logic [2*COORD_W-1:0] dx_w, dy_w;
  logic [RO_W-1:0]      ro, rg;
  logic [SQ_W-1:0]      ro_w, rg_w, ri_w;
  logic [2*COORD_W-1:0] dx2_r, dy2_r;
  logic [SQ_W-1:0]      ro2_r, rg2_r, ri2_r;
  logic [D2_W-1:0]      d2;

  assign dx = (col >= cfg.center_x) ? col - cfg.center_x : cfg.center_x - col;
  assign dy = (row >= cfg.center_y) ? row - cfg.center_y : cfg.center_y - row;
  assign ro = {1'b0, cfg.outer_radius} + RO_W'(1);
  assign rg = {1'b0, cfg.inner_radius} + RO_W'(EDGE_GUARD);

  // operands widened to the product width
  assign dx_w = {{COORD_W{1'b0}}, dx};
  assign dy_w = {{COORD_W{1'b0}}, dy};
  assign ro_w = {{(SQ_W-RO_W){1'b0}}, ro};
  assign rg_w = {{(SQ_W-RO_W){1'b0}}, rg};
  assign ri_w = {{(SQ_W-RAD_W){1'b0}}, cfg.inner_radius};

  // squares registered on the accept edge
  always_ff @(posedge clk) begin
    if (load) begin
      dx2_r <= dx_w * dx_w;
      dy2_r <= dy_w * dy_w;
      ro2_r <= ro_w * ro_w;
      rg2_r <= rg_w * rg_w;
      ri2_r <= ri_w * ri_w;
    end
  end

  // floor(dist) <= R  <=>  d2 < (R+1)^2 ;  floor(dist) >= R  <=>  d2 >= R^2
  assign d2           = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign ring.in_ring = (SQ_W'(d2) < ro2_r) && (SQ_W'(d2) >= ri2_r);
  assign ring.guard   = SQ_W'(d2) >= rg2_r;
endmodule

// ----- sv/ring_gray_histogram_marker.sv -----
// Channel  Dir  Handshake      Payload
// in_if    in   valid/ready    func, col, row, pixel_in
// out_if   out  valid/ready    pixel_out, bin_count, max_count
// cfg      in   APB write/read center_x, center_y, outer_radius, inner_radius
//
// One transaction per cycle sustained while out_if.ready is high. On the way to
// out_if.valid, the accept edge squares the offsets and reads the bin RAM, and
// the update stage then does the bin read-modify-write and loads the output register.
// rst_n is synchronous: it clears the config registers, all bin valid bits and
// the peak; the bin RAM itself is not swept (valid bits gate its contents).
// A stalled output register holds the update stage, which holds in_if.ready.
`include "ring_gray_histogram_marker_defines.svh"

module ring_gray_histogram_marker (
  input  logic                        clk,
  input  logic                        rst_n,
  rghm_in_if.sink                     in_if,
  rghm_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rghm_pkg::CFG_AW-1:0] paddr,
  input  logic [rghm_pkg::CFG_DW-1:0] pwdata,
  output logic [rghm_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import rghm_pkg::*;

  // ---------------- configuration registers ----------------
  cfg_t     cfg_r;
  logic     cfg_we;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x     <= CENTER_X_RST;
      cfg_r.center_y     <= CENTER_Y_RST;
      cfg_r.outer_radius <= OUTER_RST;
      cfg_r.inner_radius <= INNER_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X: cfg_r.center_x     <= pwdata[COORD_W-1:0];
        REG_CENTER_Y: cfg_r.center_y     <= pwdata[COORD_W-1:0];
        REG_OUTER:    cfg_r.outer_radius <= pwdata[RAD_W-1:0];
        REG_INNER:    cfg_r.inner_radius <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X: prdata = CFG_DW'(cfg_r.center_x);
      REG_CENTER_Y: prdata = CFG_DW'(cfg_r.center_y);
      REG_OUTER:    prdata = CFG_DW'(cfg_r.outer_radius);
      REG_INNER:    prdata = CFG_DW'(cfg_r.inner_radius);
      default:      prdata = '0;
    endcase
  end

  // ---------------- handshake and stage control ----------------
  logic              in_acc;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_go;
  logic [1:0]        s1_func_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              out_valid_r, out_valid_nxt;

  // update stage retires when the output register is free or draining
  assign s1_go        = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || s1_go;
  assign in_acc       = in_if.valid && in_if.ready;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_go || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_if.func;
      s1_pix_r  <= in_if.pixel_in;
    end
  end

  // ---------------- ring test ----------------
  ring_t ring;

  rghm_ring u_ring (
    .clk  (clk),
    .load (in_acc),
    .col  (in_if.col),
    .row  (in_if.row),
    .cfg  (cfg_r),
    .ring (ring)
  );

  // ---------------- bin memory, read on accept ----------------
  logic                  ram_we;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_inc;
  logic [NUM_BINS-1:0]   bin_valid_r;
  logic                  fwd_valid_r;
  logic [BIN_AW-1:0]     fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic                  fwd_hit;
  logic                  count_en;
  logic                  is_pixel, is_read, is_clear;
  logic [COUNT_BITS-1:0] peak_r, peak_nxt;

  rghm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_pix_r),
    .wdata (cnt_inc),
    .re    (in_acc),
    .raddr (in_if.pixel_in),
    .rdata (ram_rdata)
  );

  assign is_pixel = s1_func_r == FUNC_PIXEL;
  assign is_read  = s1_func_r == FUNC_READ;
  assign is_clear = s1_func_r == FUNC_CLEAR;

  // last written entry overrides RAM data read in the same cycle as the write;
  // it always holds the newest count of its own bin
  assign fwd_hit  = fwd_valid_r && (fwd_addr_r == s1_pix_r);
  assign cnt_cur  = !bin_valid_r[s1_pix_r] ? '0 : (fwd_hit ? fwd_data_r : ram_rdata);
  assign cnt_inc  = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
  assign count_en = is_pixel && ring.in_ring && (s1_pix_r != '0);
  assign ram_we   = s1_go && count_en;

  always_comb begin
    peak_nxt = peak_r;
    if (is_clear) begin
      peak_nxt = '0;
    end else if (count_en && (cnt_inc > peak_r)) begin
      peak_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_valid_r <= '0;
      peak_r      <= '0;
      fwd_valid_r <= 1'b0;
    end else if (s1_go) begin
      peak_r <= peak_nxt;
      if (is_clear) begin
        bin_valid_r <= '0;
      end else if (count_en) begin
        bin_valid_r[s1_pix_r] <= 1'b1;
        fwd_valid_r           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr_r <= s1_pix_r;
      fwd_data_r <= cnt_inc;
    end
  end

  // ---------------- output register ----------------
  logic [PIX_W-1:0]      pix_res;
  logic [PIX_W-1:0]      out_pix_r;
  logic [COUNT_BITS-1:0] out_bin_r, out_max_r;

  always_comb begin
    pix_res = '0;
    if (count_en) begin
      // far from the inner edge, dim pixels get marked
      pix_res = (ring.guard && (s1_pix_r < MARK_THRESH)) ? MARK_VALUE : s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_pix_r <= pix_res;
      out_bin_r <= is_read ? cnt_cur : '0;
      out_max_r <= peak_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.pixel_out = out_pix_r;
  assign out_if.bin_count = out_bin_r;
  assign out_if.max_count = out_max_r;

  // ---------------- checks ----------------
  `RGHM_ASSERT_NXT(a_clear_zeroes_peak, s1_go && is_clear, peak_r == '0, "peak not cleared")
  `RGHM_ASSERT_NXT(a_write_sets_valid, ram_we, bin_valid_r[$past(s1_pix_r)], "bin valid not set")
  `RGHM_ASSERT_NXT(a_peak_covers_write, ram_we, peak_r >= $past(cnt_inc), "peak below bin")
  `RGHM_ASSERT_IMP(a_out_from_stage, $rose(out_valid_r), $past(s1_go), "result without update")
endmodule

// ----- bench/tb_ring_gray_histogram_marker.sv -----
module tb_ring_gray_histogram_marker;
  timeunit 1ns;
  timeprecision 1ps;

  import rghm_pkg::*;

  // func code 3 has no name in the package; the block must treat it as a no-op
  localparam logic [1:0] FUNC_UNUSED    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         SETTLE_CYCLES  = 4;    // two-stage pipe plus margin
  localparam int         LONG_HOLD      = 60;   // receiver hold-off, cycles
  localparam int         PHASE_ITEMS    = 170;

  typedef struct packed {
    logic [PIX_W-1:0]      pixel_out;
    logic [COUNT_BITS-1:0] bin_count;
    logic [COUNT_BITS-1:0] max_count;
  } ring_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  rghm_in_if  in_ch ();
  rghm_out_if out_ch ();

  ring_gray_histogram_marker u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the ring registers and of the histogram, updated at the edges
  // where the block itself takes a register write or an input transaction.
  cfg_t                  ring_cfg;
  logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
  bit                    hist_live [NUM_BINS];
  logic [COUNT_BITS-1:0] hist_peak;

  // Bins that were ever written: reads are only issued to these, the bin RAM
  // is not cleared by reset.
  bit                    bin_written [NUM_BINS];
  logic [PIX_W-1:0]      last_bin;

  ring_result_t          due_results[$];
  int                    mismatch_count;
  int                    quiet_cycles;

  // Idle controls: tx side gaps in send_pixel_cmd, rx side in the ready process
  bit                    tx_idle_en;
  bit                    rx_idle_en;
  int                    rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint abs_diff(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Applies one command to the shadow histogram and returns what the block
  // must send for it. Ring membership uses floor(dist): inside iff
  // inner^2 <= d2 < (outer+1)^2; marking needs d2 >= (inner+5)^2.
  function automatic ring_result_t mark_and_count(logic [1:0] f, logic [COORD_W-1:0] c,
                                                  logic [COORD_W-1:0] r, logic [PIX_W-1:0] p);
    ring_result_t          res;
    longint                dx;
    longint                dy;
    longint                d2;
    longint                ro;
    longint                ri;
    longint                rg;
    logic [COUNT_BITS-1:0] cnt;
    res = '0;
    case (f)
      FUNC_PIXEL: begin
        dx = abs_diff(longint'(c), longint'(ring_cfg.center_x));
        dy = abs_diff(longint'(r), longint'(ring_cfg.center_y));
        d2 = dx * dx + dy * dy;
        ro = longint'(ring_cfg.outer_radius) + 1;
        ri = longint'(ring_cfg.inner_radius);
        rg = ri + EDGE_GUARD;
        // zero pixels inside the ring are neither counted nor passed
        if (d2 < ro * ro && d2 >= ri * ri && p != '0) begin
          cnt = hist_live[p] ? hist_bins[p] : '0;
          if (cnt != {COUNT_BITS{1'b1}}) cnt = cnt + 1'b1;
          hist_bins[p]   = cnt;
          hist_live[p]   = 1'b1;
          bin_written[p] = 1'b1;
          last_bin       = p;
          if (cnt > hist_peak) hist_peak = cnt;
          res.pixel_out = p;
          if (d2 >= rg * rg && p < MARK_THRESH) res.pixel_out = MARK_VALUE;
        end
      end
      FUNC_READ: begin
        res.bin_count = hist_live[p] ? hist_bins[p] : '0;
      end
      FUNC_CLEAR: begin
        foreach (hist_live[i]) hist_live[i] = 1'b0;
        hist_peak = '0;
      end
      default: ;
    endcase
    res.max_count = hist_peak;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one transaction, holds it until accepted, then predicts its result.
  // Returns at the accepting edge with valid still high.
  task automatic send_pixel_cmd(logic [1:0] f, logic [COORD_W-1:0] c,
                                logic [COORD_W-1:0] r, logic [PIX_W-1:0] p);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.col      <= c;
    in_ch.row      <= r;
    in_ch.pixel_in <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due_results.insert(due_results.size(), mark_and_count(f, c, r, p));
  endtask

  // Stops the input and waits until every predicted result has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge where psel, penable, pwrite and pready are all high.
  task automatic write_ring_reg(reg_idx_t idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CENTER_X: ring_cfg.center_x     = COORD_W'(value);
      REG_CENTER_Y: ring_cfg.center_y     = COORD_W'(value);
      REG_OUTER:    ring_cfg.outer_radius = RAD_W'(value);
      REG_INNER:    ring_cfg.inner_radius = RAD_W'(value);
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Must only be called with the block drained.
  task automatic set_ring(int cx, int cy, int outer, int inner);
    write_ring_reg(REG_CENTER_X, cx);
    write_ring_reg(REG_CENTER_Y, cy);
    write_ring_reg(REG_OUTER, outer);
    write_ring_reg(REG_INNER, inner);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int int_sqrt(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 1023) return COORD_W'(1023);
    return COORD_W'(v);
  endfunction

  // Points at a distance from near the smaller radius to just past the larger one,
  // so pixels land on and around the inner, guard and outer boundaries.
  task automatic pick_ring_point(output logic [COORD_W-1:0] c, output logic [COORD_W-1:0] r);
    int lo;
    int hi;
    int t;
    int dx;
    int dy;
    if (ring_cfg.inner_radius <= ring_cfg.outer_radius) begin
      lo = (ring_cfg.inner_radius > 3) ? int'(ring_cfg.inner_radius) - 3 : 0;
      hi = int'(ring_cfg.outer_radius) + 3;
    end else begin
      lo = int'(ring_cfg.outer_radius);
      hi = int'(ring_cfg.inner_radius) + 3;
    end
    t  = $urandom_range(hi, lo);
    dx = $urandom_range(t, 0);
    dy = int_sqrt(t * t - dx * dx) + $urandom_range(1, 0);
    if ($urandom_range(1, 0)) dx = -dx;
    if ($urandom_range(1, 0)) dy = -dy;
    c = clamp_coord(int'(ring_cfg.center_x) + dx);
    r = clamp_coord(int'(ring_cfg.center_y) + dy);
  endtask

  // Gray values biased to zero, the mark threshold and the extremes.
  function automatic logic [PIX_W-1:0] pick_gray();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return PIX_W'($urandom_range(151, 148));
      2:       return '1;
      3:       return PIX_W'(1);
      default: return PIX_W'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic send_random_cmd();
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    logic [PIX_W-1:0]   p;
    int                 sel;
    sel = $urandom_range(99, 0);
    if (sel < 70) begin
      pick_ring_point(c, r);
      send_pixel_cmd(FUNC_PIXEL, c, r, pick_gray());
    end else if (sel < 80) begin
      send_pixel_cmd(FUNC_PIXEL, COORD_W'($urandom), COORD_W'($urandom), pick_gray());
    end else if (sel < 92) begin
      // only bins that hold a written count, live or cleared
      p = PIX_W'($urandom);
      if (!bin_written[p]) p = last_bin;
      send_pixel_cmd(FUNC_READ, COORD_W'($urandom), COORD_W'($urandom), p);
    end else if (sel < 96) begin
      send_pixel_cmd(FUNC_CLEAR, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
    end else begin
      send_pixel_cmd(FUNC_UNUSED, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset ring: center (512,512), inner 300, outer 400, guard from 305.
  task automatic test_ring_boundaries();
    send_pixel_cmd(FUNC_PIXEL, 10'd512, 10'd512, 8'd200); // center, outside
    send_pixel_cmd(FUNC_PIXEL, 10'd811, 10'd512, 8'd77);  // 299, just inside hole
    send_pixel_cmd(FUNC_PIXEL, 10'd812, 10'd512, 8'd77);  // 300, inner edge
    send_pixel_cmd(FUNC_PIXEL, 10'd912, 10'd512, 8'd200); // 400, outer edge
    send_pixel_cmd(FUNC_PIXEL, 10'd913, 10'd512, 8'd200); // 401, outside
    send_pixel_cmd(FUNC_PIXEL, 10'd512, 10'd816, 8'd149); // 304, inside guard
    send_pixel_cmd(FUNC_PIXEL, 10'd512, 10'd817, 8'd149); // 305, marked
    send_pixel_cmd(FUNC_PIXEL, 10'd512, 10'd817, 8'd150); // 305, not dark enough
    send_pixel_cmd(FUNC_PIXEL, 10'd512, 10'd212, 8'd0);   // zero pixel in ring
    send_pixel_cmd(FUNC_PIXEL, 10'd112, 10'd512, 8'd255);
    send_pixel_cmd(FUNC_PIXEL, 10'd0, 10'd0, 8'd1);
    send_pixel_cmd(FUNC_PIXEL, 10'd1023, 10'd1023, 8'd254);
  endtask

  task automatic test_commands();
    send_pixel_cmd(FUNC_READ, 10'd0, 10'd0, 8'd149);
    send_pixel_cmd(FUNC_UNUSED, 10'd1023, 10'd1023, 8'd255);
    send_pixel_cmd(FUNC_CLEAR, 10'd0, 10'd0, 8'd0);
    send_pixel_cmd(FUNC_READ, 10'd0, 10'd0, 8'd149);      // empty after clear
    send_pixel_cmd(FUNC_PIXEL, 10'd812, 10'd512, 8'd149); // recount from 1
  endtask

  // Register extremes: single-pixel ring, full-image ring, empty ring.
  task automatic test_ring_settings();
    drain_results();
    set_ring(0, 0, 0, 0);
    send_pixel_cmd(FUNC_PIXEL, 10'd0, 10'd0, 8'd10);
    send_pixel_cmd(FUNC_PIXEL, 10'd1, 10'd0, 8'd10);
    drain_results();
    set_ring(1023, 1023, 1448, 0);
    send_pixel_cmd(FUNC_PIXEL, 10'd0, 10'd0, 8'd140);
    send_pixel_cmd(FUNC_PIXEL, 10'd1023, 10'd1023, 8'd140);
    drain_results();
    set_ring(1023, 1023, 499, 500);                      // inner above outer
    send_pixel_cmd(FUNC_PIXEL, 10'd1023, 10'd523, 8'd50);
    send_pixel_cmd(FUNC_READ, 10'd0, 10'd0, 8'd10);
  endtask

  // Receiver holds off while the sender keeps offering: the pipe fills and
  // in_ch.ready must drop without losing or duplicating a transaction.
  task automatic test_backpressure();
    drain_results();
    set_ring(512, 512, 400, 300);
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = LONG_HOLD;
    repeat (24) send_random_cmd();
    drain_results();
  endtask

  // Phases with changing ring settings and idling; each phase starts drained.
  task automatic test_random_traffic();
    int outer;
    int inner;
    for (int ph = 0; ph < 7; ph++) begin
      drain_results();
      case (ph)
        0: set_ring(0, 1023, 1448, 0);
        1: set_ring(1023, 0, 0, 0);
        2: set_ring(512, 512, 200, 200);
        3: set_ring(300, 700, 1448, 1443);
        default: begin
          outer = $urandom_range(1448, 0);
          inner = ($urandom_range(5, 0) == 0) ? $urandom_range(1448, 0)
                                              : $urandom_range(outer, 0);
          set_ring($urandom_range(1023, 0), $urandom_range(1023, 0), outer, inner);
        end
      endcase
      // phase 1 runs without idling on either side
      tx_idle_en = (ph != 1) && ($urandom_range(3, 0) != 0);
      rx_idle_en = (ph != 1) && ($urandom_range(3, 0) != 0);
      repeat (PHASE_ITEMS) send_random_cmd();
    end
  endtask

  task automatic test_quiet_tail();
    drain_results();
    set_ring(512, 512, 400, 300);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (150) send_random_cmd();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= FUNC_PIXEL;
    in_ch.col      <= '0;
    in_ch.row      <= '0;
    in_ch.pixel_in <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    mismatch_count = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rx_hold_req    = 0;
    last_bin       = '0;
    hist_peak      = '0;
    ring_cfg       = '{CENTER_X_RST, CENTER_Y_RST, OUTER_RST, INNER_RST};
    foreach (hist_live[i]) begin
      hist_live[i]   = 1'b0;
      bin_written[i] = 1'b0;
      hist_bins[i]   = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ring_boundaries();
    test_commands();
    test_ring_settings();
    test_backpressure();
    test_random_traffic();
    test_quiet_tail();

    drain_results();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stall bursts when enabled, or one long hold-off when a test
  // requests it.
  initial begin
    int rx_gap;
    rx_gap = 0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        rx_gap      = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_gap == 0 && rx_idle_en && $urandom_range(5, 0) == 0) begin
        rx_gap = $urandom_range(9, 1);
      end
      if (rx_gap > 0) begin
        out_ch.ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every output transaction against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    ring_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected transaction pixel_out %0d bin_count %0d max_count %0d",
                 $time, out_ch.pixel_out, out_ch.bin_count, out_ch.max_count);
        mismatch_count++;
      end else begin
        exp_res = due_results.pop_front();
        if (out_ch.pixel_out !== exp_res.pixel_out) begin
          $display("%0t: pixel_out expected %0d got %0d",
                   $time, exp_res.pixel_out, out_ch.pixel_out);
          mismatch_count++;
        end
        if (out_ch.bin_count !== exp_res.bin_count) begin
          $display("%0t: bin_count expected %0d got %0d",
                   $time, exp_res.bin_count, out_ch.bin_count);
          mismatch_count++;
        end
        if (out_ch.max_count !== exp_res.max_count) begin
          $display("%0t: max_count expected %0d got %0d",
                   $time, exp_res.max_count, out_ch.max_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without a transaction on either channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, due_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

endmodule
